>>> sv/bts_pkg.sv
package bts_pkg;

    // Store geometry and position format.
    localparam int MAX_WIDTH     = 256;
    localparam int MAX_HEIGHT    = 256;
    localparam int FRACTION_BITS = 8;

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int U_POS_W     = COL_W + FRACTION_BITS;
    localparam int V_POS_W     = ROW_W + FRACTION_BITS;

    // Fixed field widths of the ports.
    localparam int COORD_W    = 32;
    localparam int TADDR_W    = 16;
    localparam int COLOR_W    = 24;
    localparam int CFG_SIZE_W = 9;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // The scaled coordinate keeps product bits 63 down to 32 - FRACTION_BITS.
    localparam int RAW_W  = 32 + FRACTION_BITS;
    localparam int WGT_W  = 2 * FRACTION_BITS + 1;
    localparam int PROD_W = 8 + WGT_W;
    localparam int SUM_W  = PROD_W + 2;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Transaction kinds.
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_U_ORIGIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_V_ORIGIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_U_SCALE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_V_SCALE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 3'd5;

    typedef logic [COLOR_W-1:0] texel_t;
    typedef logic [WGT_W-1:0]   weight_t;
    typedef logic [PROD_W-1:0]  prod_t;

endpackage

>>> sv/bilinear_texel_sampler.sv
// Channel   Direction  Handshake                  Payload
// item      in         item_valid / item_stall    kind, u_coord, v_coord, texel_address,
//                                                 texel_color
// result    out        result_valid / result_stall sample_color
// cfg       in         cfg_we                     cfg_index, cfg_data
//
// One transaction enters per clock while item_stall is low; a sample result leaves from stage 7.
// The rate is set by the two texel store copies, each with one write and two read ports,
// so all four neighbors of a sample are read in the same cycle.
// Write transactions produce no result and leave the pipeline after the store stage.
// Reset clears the pipeline valid bits and sets the configuration to its defaults; the store is not cleared.
// A stall on the result side holds the last stage; earlier stages keep filling bubbles.
module bilinear_texel_sampler
    import bts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic                  kind,
    input  logic [COORD_W-1:0]    u_coord,
    input  logic [COORD_W-1:0]    v_coord,
    input  logic [TADDR_W-1:0]    texel_address,
    input  logic [COLOR_W-1:0]    texel_color,

    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [31:0]           sample_color,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration.
    logic [31:0]           u_origin_reg;
    logic [31:0]           v_origin_reg;
    logic [31:0]           u_scale_reg;
    logic [31:0]           v_scale_reg;
    logic [CFG_SIZE_W-1:0] map_width_reg;
    logic [CFG_SIZE_W-1:0] map_height_reg;

    logic [CFG_SIZE_W-1:0] width_sat;
    logic [CFG_SIZE_W-1:0] height_sat;
    logic [U_POS_W-1:0]    u_top;
    logic [V_POS_W-1:0]    v_top;

    // Pipeline flow control.
    logic [7:1] stage_valid_reg;
    logic [8:1] stage_ready;

    // Stage 1: offsets.
    logic                 kind1_reg;
    logic [TADDR_W-1:0]   waddr1_reg;
    logic [COLOR_W-1:0]   wcolor1_reg;
    logic [32:0]          du_reg;
    logic [32:0]          dv_reg;
    logic [32:0]          du_next;
    logic [32:0]          dv_next;

    // Stage 2: scaled positions.
    logic                 kind2_reg;
    logic [TADDR_W-1:0]   waddr2_reg;
    logic [COLOR_W-1:0]   wcolor2_reg;
    logic [RAW_W-1:0]     pu_raw_reg;
    logic [RAW_W-1:0]     pv_raw_reg;
    logic [RAW_W-1:0]     pu_raw_next;
    logic [RAW_W-1:0]     pv_raw_next;
    logic [63:0]          u_product;
    logic [63:0]          v_product;

    // Stage 3: clamped positions.
    logic                 kind3_reg;
    logic [TADDR_W-1:0]   waddr3_reg;
    logic [COLOR_W-1:0]   wcolor3_reg;
    logic [U_POS_W-1:0]   pu_reg;
    logic [V_POS_W-1:0]   pv_reg;
    logic [U_POS_W-1:0]   pu_next;
    logic [V_POS_W-1:0]   pv_next;

    // Stage 4: neighbor addresses.
    logic                     kind4_reg;
    logic [TADDR_W-1:0]       waddr4_reg;
    logic [COLOR_W-1:0]       wcolor4_reg;
    logic [ADDR_W-1:0]        addr_reg [4];
    logic [ADDR_W-1:0]        base;
    logic [ADDR_W-1:0]        iv_ext;
    logic [ADDR_W-1:0]        w_ext;
    logic [FRACTION_BITS-1:0] fx4_reg;
    logic [FRACTION_BITS-1:0] fy4_reg;
    logic                     store_write;

    // Stage 5: texels and weights.
    texel_t                   texel_reg [4];
    weight_t                  weight_reg [4];
    logic [FRACTION_BITS:0]   fx_inv;
    logic [FRACTION_BITS:0]   fy_inv;

    // Stage 6: per-channel products; stage 7: result.
    prod_t                    prod_reg [3][4];
    logic [31:0]              sample_reg;
    logic [7:0]               chan [3];

    // Two copies of the store give four read ports in total.
    texel_t texel_mem_top [STORE_DEPTH];
    texel_t texel_mem_bot [STORE_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_origin_reg   <= '0;
            v_origin_reg   <= '0;
            u_scale_reg    <= 32'd65536;
            v_scale_reg    <= 32'd65536;
            map_width_reg  <= CFG_SIZE_W'(2);
            map_height_reg <= CFG_SIZE_W'(2);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_U_ORIGIN:   u_origin_reg   <= cfg_data;
                CFG_V_ORIGIN:   v_origin_reg   <= cfg_data;
                CFG_U_SCALE:    u_scale_reg    <= cfg_data;
                CFG_V_SCALE:    v_scale_reg    <= cfg_data;
                CFG_MAP_WIDTH:  map_width_reg  <= cfg_data[CFG_SIZE_W-1:0];
                CFG_MAP_HEIGHT: map_height_reg <= cfg_data[CFG_SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (map_width_reg < CFG_SIZE_W'(2))
            width_sat = CFG_SIZE_W'(2);
        else if (map_width_reg > CFG_SIZE_W'(MAX_WIDTH))
            width_sat = CFG_SIZE_W'(MAX_WIDTH);
        else
            width_sat = map_width_reg;

        if (map_height_reg < CFG_SIZE_W'(2))
            height_sat = CFG_SIZE_W'(2);
        else if (map_height_reg > CFG_SIZE_W'(MAX_HEIGHT))
            height_sat = CFG_SIZE_W'(MAX_HEIGHT);
        else
            height_sat = map_height_reg;

        // Last legal position: index size-2 with an all-ones fraction.
        u_top = {COL_W'(width_sat - CFG_SIZE_W'(1)), {FRACTION_BITS{1'b0}}} - U_POS_W'(1);
        v_top = {ROW_W'(height_sat - CFG_SIZE_W'(1)), {FRACTION_BITS{1'b0}}} - V_POS_W'(1);
    end

    // A stage may load when it is empty or its content moves on.
    always_comb
    begin
        stage_ready[8] = !result_stall;
        for (int k = 7; k >= 1; k--)
            stage_ready[k] = !stage_valid_reg[k] || stage_ready[k+1];
    end

    assign item_stall   = !stage_ready[1];
    assign result_valid = stage_valid_reg[7];
    assign sample_color = sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else
        begin
            if (stage_ready[1])
                stage_valid_reg[1] <= item_valid;
            if (stage_ready[2])
                stage_valid_reg[2] <= stage_valid_reg[1];
            if (stage_ready[3])
                stage_valid_reg[3] <= stage_valid_reg[2];
            if (stage_ready[4])
                stage_valid_reg[4] <= stage_valid_reg[3];
            // Write transactions end at the store.
            if (stage_ready[5])
                stage_valid_reg[5] <= stage_valid_reg[4] && (kind4_reg == KIND_SAMPLE);
            if (stage_ready[6])
                stage_valid_reg[6] <= stage_valid_reg[5];
            if (stage_ready[7])
                stage_valid_reg[7] <= stage_valid_reg[6];
        end
    end

    always_comb
    begin
        du_next = {u_coord[31], u_coord} - {u_origin_reg[31], u_origin_reg};
        dv_next = {v_coord[31], v_coord} - {v_origin_reg[31], v_origin_reg};

        u_product = du_reg[31:0] * u_scale_reg;
        v_product = dv_reg[31:0] * v_scale_reg;

        // A non-positive offset maps to position zero.
        if (du_reg[32] || du_reg == '0)
            pu_raw_next = '0;
        else
            pu_raw_next = u_product[63:32-FRACTION_BITS];
        if (dv_reg[32] || dv_reg == '0)
            pv_raw_next = '0;
        else
            pv_raw_next = v_product[63:32-FRACTION_BITS];

        if (pu_raw_reg > RAW_W'(u_top))
            pu_next = u_top;
        else
            pu_next = pu_raw_reg[U_POS_W-1:0];
        if (pv_raw_reg > RAW_W'(v_top))
            pv_next = v_top;
        else
            pv_next = pv_raw_reg[V_POS_W-1:0];

        iv_ext = ADDR_W'(pv_reg[V_POS_W-1:FRACTION_BITS]);
        w_ext  = ADDR_W'(width_sat);
        base   = iv_ext * w_ext + ADDR_W'(pu_reg[U_POS_W-1:FRACTION_BITS]);

        fx_inv = (FRACTION_BITS+1)'(1 << FRACTION_BITS) - {1'b0, fx4_reg};
        fy_inv = (FRACTION_BITS+1)'(1 << FRACTION_BITS) - {1'b0, fy4_reg};

        store_write = stage_valid_reg[4] && (kind4_reg == KIND_WRITE) && stage_ready[5]
                      && (32'(waddr4_reg) < STORE_DEPTH);

        for (int ch = 0; ch < 3; ch++)
            chan[ch] = 8'((SUM_W'(prod_reg[ch][0]) + SUM_W'(prod_reg[ch][1])
                           + SUM_W'(prod_reg[ch][2]) + SUM_W'(prod_reg[ch][3]))
                          >> (2 * FRACTION_BITS));
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[1])
        begin
            kind1_reg   <= kind;
            waddr1_reg  <= texel_address;
            wcolor1_reg <= texel_color;
            du_reg      <= du_next;
            dv_reg      <= dv_next;
        end
        if (stage_ready[2])
        begin
            kind2_reg   <= kind1_reg;
            waddr2_reg  <= waddr1_reg;
            wcolor2_reg <= wcolor1_reg;
            pu_raw_reg  <= pu_raw_next;
            pv_raw_reg  <= pv_raw_next;
        end
        if (stage_ready[3])
        begin
            kind3_reg   <= kind2_reg;
            waddr3_reg  <= waddr2_reg;
            wcolor3_reg <= wcolor2_reg;
            pu_reg      <= pu_next;
            pv_reg      <= pv_next;
        end
        if (stage_ready[4])
        begin
            kind4_reg   <= kind3_reg;
            waddr4_reg  <= waddr3_reg;
            wcolor4_reg <= wcolor3_reg;
            addr_reg[0] <= base;
            addr_reg[1] <= base + ADDR_W'(1);
            addr_reg[2] <= base + w_ext;
            addr_reg[3] <= base + w_ext + ADDR_W'(1);
            fx4_reg     <= pu_reg[FRACTION_BITS-1:0];
            fy4_reg     <= pv_reg[FRACTION_BITS-1:0];
        end
        if (stage_ready[5])
        begin
            weight_reg[0] <= WGT_W'(fx_inv) * WGT_W'(fy_inv);
            weight_reg[1] <= WGT_W'(fx4_reg) * WGT_W'(fy_inv);
            weight_reg[2] <= WGT_W'(fx_inv) * WGT_W'(fy4_reg);
            weight_reg[3] <= WGT_W'(fx4_reg) * WGT_W'(fy4_reg);
        end
        if (stage_ready[6])
        begin
            for (int ch = 0; ch < 3; ch++)
                for (int t = 0; t < 4; t++)
                    prod_reg[ch][t] <= PROD_W'(texel_reg[t][8*ch +: 8]) * PROD_W'(weight_reg[t]);
        end
        if (stage_ready[7])
            sample_reg <= {ALPHA_OPAQUE, chan[2], chan[1], chan[0]};
    end

    // Writes and reads happen in the same stage, so pipeline order is store order.
    always_ff @(posedge clk)
    begin
        if (store_write)
        begin
            texel_mem_top[ADDR_W'(waddr4_reg)] <= wcolor4_reg;
            texel_mem_bot[ADDR_W'(waddr4_reg)] <= wcolor4_reg;
        end
        if (stage_ready[5])
        begin
            texel_reg[0] <= texel_mem_top[addr_reg[0]];
            texel_reg[1] <= texel_mem_top[addr_reg[1]];
            texel_reg[2] <= texel_mem_bot[addr_reg[2]];
            texel_reg[3] <= texel_mem_bot[addr_reg[3]];
        end
    end

endmodule

>>> verif/bilinear_texel_sampler_test.sv
module bilinear_texel_sampler_test;
    import bts_pkg::*;

    localparam int PIPE_LATENCY = 7;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 75;
    localparam int LONG_HOLD    = 300;

    typedef longint unsigned u64_t;

    typedef enum logic [1:0] {
        ACT_ITEM,
        ACT_CHECKED,
        ACT_REG
    } row_action_t;

    typedef struct packed {
        logic                kind;
        logic [COORD_W-1:0]  u;
        logic [COORD_W-1:0]  v;
        logic [TADDR_W-1:0]  addr;
        logic [COLOR_W-1:0]  color;
    } texel_item_t;

    typedef struct packed {
        row_action_t           act;
        texel_item_t           item;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [31:0]           color;
    } directed_row_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    logic                  kind = KIND_WRITE;
    logic [COORD_W-1:0]    u_coord = '0;
    logic [COORD_W-1:0]    v_coord = '0;
    logic [TADDR_W-1:0]    texel_address = '0;
    logic [COLOR_W-1:0]    texel_color = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    logic [31:0]           sample_color;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Copy of the block's configuration and texel store, updated as transactions are accepted.
    logic [31:0]            u_origin_q = 32'h0;
    logic [31:0]            v_origin_q = 32'h0;
    logic [31:0]            u_scale_q = 32'h0001_0000;
    logic [31:0]            v_scale_q = 32'h0001_0000;
    logic [CFG_SIZE_W-1:0]  map_width_q = 9'd2;
    logic [CFG_SIZE_W-1:0]  map_height_q = 9'd2;
    logic [COLOR_W-1:0]     texel_mirror [STORE_DEPTH];
    bit                     texel_written [STORE_DEPTH];

    logic [31:0] expected_colors [$];
    int          mismatch_count = 0;
    int unsigned items_sent = 0;
    bit          quiet_phase = 1'b0;
    int unsigned long_hold_cycles = 0;

    bilinear_texel_sampler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .kind          (kind),
        .u_coord       (u_coord),
        .v_coord       (v_coord),
        .texel_address (texel_address),
        .texel_color   (texel_color),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .sample_color  (sample_color),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int unsigned clamp_size(logic [CFG_SIZE_W-1:0] size, int unsigned top);
        if (size < 2)
            return 2;
        if (size > top)
            return top;
        return 32'(size);
    endfunction

    // Position in texel units with FRACTION_BITS fraction bits, clamped to the last cell.
    function automatic u64_t texel_position(logic [31:0] coord, logic [31:0] origin,
                                            logic [31:0] scale, int unsigned size);
        longint d;
        u64_t   p;
        u64_t   top;
        d = longint'($signed(coord)) - longint'($signed(origin));
        top = (u64_t'(size - 1) << FRACTION_BITS) - 1;
        if (d <= 0)
            return 0;
        p = (u64_t'(d) * scale) >> (32 - FRACTION_BITS);
        return (p > top) ? top : p;
    endfunction

    function automatic void locate_sample(input logic [31:0] u, input logic [31:0] v,
                                          output int unsigned base, output int unsigned stride,
                                          output int unsigned fx, output int unsigned fy);
        int unsigned rows;
        u64_t        pu;
        u64_t        pv;
        stride = clamp_size(map_width_q, MAX_WIDTH);
        rows = clamp_size(map_height_q, MAX_HEIGHT);
        pu = texel_position(u, u_origin_q, u_scale_q, stride);
        pv = texel_position(v, v_origin_q, v_scale_q, rows);
        fx = 32'(pu % (1 << FRACTION_BITS));
        fy = 32'(pv % (1 << FRACTION_BITS));
        base = 32'((pv >> FRACTION_BITS) * stride + (pu >> FRACTION_BITS));
    endfunction

    function automatic logic [31:0] predict_filtered_color(logic [31:0] u, logic [31:0] v);
        int unsigned        base;
        int unsigned        stride;
        int unsigned        fx;
        int unsigned        fy;
        int unsigned        one;
        logic [COLOR_W-1:0] corner [4];
        u64_t               wgt [4];
        u64_t               acc;
        logic [31:0]        color;
        locate_sample(u, v, base, stride, fx, fy);
        one = 1 << FRACTION_BITS;
        corner[0] = texel_mirror[base % STORE_DEPTH];
        corner[1] = texel_mirror[(base + 1) % STORE_DEPTH];
        corner[2] = texel_mirror[(base + stride) % STORE_DEPTH];
        corner[3] = texel_mirror[(base + stride + 1) % STORE_DEPTH];
        wgt[0] = u64_t'((one - fx) * (one - fy));
        wgt[1] = u64_t'(fx * (one - fy));
        wgt[2] = u64_t'((one - fx) * fy);
        wgt[3] = u64_t'(fx * fy);
        color = {ALPHA_OPAQUE, 24'h0};
        for (int ch = 0; ch < 3; ch++)
        begin
            acc = 0;
            for (int k = 0; k < 4; k++)
                acc += corner[k][ch*8 +: 8] * wgt[k];
            color[ch*8 +: 8] = 8'(acc >> (2 * FRACTION_BITS));
        end
        return color;
    endfunction

    function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
    endfunction

    function automatic texel_item_t make_write(logic [TADDR_W-1:0] addr,
                                               logic [COLOR_W-1:0] color);
        texel_item_t it;
        it.kind = KIND_WRITE;
        it.u = $urandom;
        it.v = $urandom;
        it.addr = addr;
        it.color = color;
        return it;
    endfunction

    function automatic texel_item_t make_sample(logic [31:0] u, logic [31:0] v);
        texel_item_t it;
        it.kind = KIND_SAMPLE;
        it.u = u;
        it.v = v;
        it.addr = TADDR_W'($urandom);
        it.color = COLOR_W'($urandom);
        return it;
    endfunction

    function automatic directed_row_t item_row(texel_item_t it);
        directed_row_t r;
        r.act = ACT_ITEM;
        r.item = it;
        return r;
    endfunction

    function automatic directed_row_t checked_row(texel_item_t it, logic [31:0] color);
        directed_row_t r;
        r.act = ACT_CHECKED;
        r.item = it;
        r.color = color;
        return r;
    endfunction

    function automatic directed_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        directed_row_t r;
        r.act = ACT_REG;
        r.reg_idx = idx;
        r.reg_data = data;
        return r;
    endfunction

    function automatic logic [CFG_SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 4))
            0: return CFG_SIZE_W'($urandom_range(0, 1));
            1: return 9'd2;
            2: return CFG_SIZE_W'($urandom_range(257, 511));
            default: return CFG_SIZE_W'($urandom_range(3, 256));
        endcase
    endfunction

    function automatic logic [31:0] pick_scale(int unsigned size, int unsigned extent);
        u64_t s;
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0001_0000;
            default:
            begin
                s = (u64_t'(size - 1) << 32) / extent;
                return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_coord(logic [31:0] origin, int unsigned extent);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return origin + $urandom_range(0, 2) - 1;
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return origin + $urandom_range(0, extent + extent / 8);
        endcase
    endfunction

    task automatic offer_item(texel_item_t it, bit typed, logic [31:0] typed_color);
        int unsigned gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        kind <= it.kind;
        u_coord <= it.u;
        v_coord <= it.v;
        texel_address <= it.addr;
        texel_color <= it.color;
        do
            @(negedge clk);
        while (item_stall);
        @(posedge clk);
        items_sent++;
        if (it.kind == KIND_WRITE)
        begin
            texel_mirror[it.addr] = it.color;
            texel_written[it.addr] = 1'b1;
        end
        else
            expected_colors.push_back(typed ? typed_color : predict_filtered_color(it.u, it.v));
    endtask

    // Every corner a sample touches gets written first; now and then one is rewritten
    // right before the sample to exercise the write-then-read path.
    task automatic offer_sample(logic [31:0] u, logic [31:0] v);
        int unsigned base;
        int unsigned stride;
        int unsigned fx;
        int unsigned fy;
        int unsigned corner_addr [4];
        locate_sample(u, v, base, stride, fx, fy);
        corner_addr[0] = base;
        corner_addr[1] = base + 1;
        corner_addr[2] = base + stride;
        corner_addr[3] = base + stride + 1;
        foreach (corner_addr[k])
            if (!texel_written[corner_addr[k] % STORE_DEPTH] || $urandom_range(0, 19) == 0)
                offer_item(make_write(corner_addr[k][TADDR_W-1:0], COLOR_W'($urandom)),
                           1'b0, 32'h0);
        offer_item(make_sample(u, v), 1'b0, 32'h0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_U_ORIGIN:   u_origin_q = data;
            CFG_V_ORIGIN:   v_origin_q = data;
            CFG_U_SCALE:    u_scale_q = data;
            CFG_V_SCALE:    v_scale_q = data;
            CFG_MAP_WIDTH:  map_width_q = data[CFG_SIZE_W-1:0];
            CFG_MAP_HEIGHT: map_height_q = data[CFG_SIZE_W-1:0];
            default: ;
        endcase
    endtask

    // Writes leave no result, so the wait runs on past the last result to let trailing writes drain.
    task automatic quiesce();
        int unsigned waited;
        item_valid <= 1'b0;
        waited = 0;
        while (expected_colors.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (PIPE_LATENCY + 3) @(posedge clk);
    endtask

    always @(negedge clk)
    begin : result_check
        logic [31:0] want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_colors.size() == 0)
                note_mismatch("result with nothing pending", 32'hx, sample_color);
            else
            begin
                want = expected_colors.pop_front();
                if (sample_color !== want)
                    note_mismatch("sample_color", want, sample_color);
            end
        end
    end

    initial
    begin
        int unsigned hold;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold_cycles > 0)
            begin
                hold = long_hold_cycles;
                long_hold_cycles = 0;
            end
            else
                hold = quiet_phase ? 0 : $urandom_range(0, 9);
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            do
                @(negedge clk);
            while (!result_valid);
            @(posedge clk);
        end
    end

    initial
    begin
        directed_row_t         rows [$];
        directed_row_t         row;
        int unsigned           phase_end;
        int unsigned           u_extent;
        int unsigned           v_extent;
        logic [31:0]           u_org;
        logic [31:0]           v_org;
        logic [CFG_SIZE_W-1:0] width_raw;
        logic [CFG_SIZE_W-1:0] height_raw;

        // Default map is 2x2 at unit scale; only texels 0..3 are read here.
        rows.push_back(item_row(make_write(16'h0000, 24'h123456)));
        rows.push_back(item_row(make_write(16'h0001, 24'hFFFFFF)));
        rows.push_back(item_row(make_write(16'h0002, 24'hFFFFFF)));
        rows.push_back(item_row(make_write(16'h0003, 24'hFFFFFF)));
        rows.push_back(checked_row(make_sample(32'h0, 32'h0), 32'hFF12_3456));
        rows.push_back(checked_row(make_sample(32'h8000_0000, 32'h8000_0000), 32'hFF12_3456));
        rows.push_back(item_row(make_sample(32'h0000_8000, 32'h0000_8000)));
        rows.push_back(item_row(make_sample(32'h7FFF_FFFF, 32'h0)));
        rows.push_back(item_row(make_sample(32'h0000_FF00, 32'h0001_0000)));
        rows.push_back(item_row(make_write(16'h0000, 24'hFFFFFF)));
        rows.push_back(checked_row(make_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF), 32'hFFFF_FFFF));
        rows.push_back(item_row(make_write(16'h0000, 24'h000000)));
        rows.push_back(checked_row(make_sample(32'h0, 32'h0), 32'hFF00_0000));
        rows.push_back(item_row(make_sample(32'h0000_4000, 32'h0000_C000)));
        // With zero scale every position collapses onto texel (0,0).
        rows.push_back(reg_row(CFG_U_SCALE, 32'h0));
        rows.push_back(reg_row(CFG_V_SCALE, 32'h0));
        rows.push_back(checked_row(make_sample(32'h7FFF_FFFF, 32'h1234_5678), 32'hFF00_0000));
        rows.push_back(reg_row(CFG_U_SCALE, 32'hFFFF_FFFF));
        rows.push_back(reg_row(CFG_V_SCALE, 32'hFFFF_FFFF));
        rows.push_back(reg_row(CFG_U_ORIGIN, 32'h7FFF_FFFF));
        rows.push_back(reg_row(CFG_V_ORIGIN, 32'h8000_0000));
        // The v difference needs 33 bits and the product the full 64.
        rows.push_back(item_row(make_sample(32'h8000_0000, 32'h7FFF_FFFF)));
        rows.push_back(checked_row(make_sample(32'h7FFF_FFFF, 32'h8000_0000), 32'hFF00_0000));
        rows.push_back(item_row(make_write(16'hFFFF, 24'hABCDEF)));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            row = rows[i];
            if (row.act == ACT_REG)
            begin
                quiesce();
                write_reg(row.reg_idx, row.reg_data);
                cfg_we <= 1'b0;
            end
            else
                offer_item(row.item, row.act == ACT_CHECKED, row.color);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            quiesce();
            width_raw = pick_size();
            height_raw = pick_size();
            u_extent = $urandom_range(1 << 8, 1 << 24);
            v_extent = $urandom_range(1 << 8, 1 << 24);
            u_org = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20);
            v_org = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20);
            if (phase == 0)
            begin
                width_raw = 9'h100;
                height_raw = 9'h1FF;
            end
            if (phase == 1)
            begin
                u_org = 32'h8000_0000;
                v_org = 32'h7FFF_FFFF;
            end
            write_reg(CFG_U_ORIGIN, u_org);
            write_reg(CFG_V_ORIGIN, v_org);
            write_reg(CFG_U_SCALE, pick_scale(clamp_size(width_raw, MAX_WIDTH), u_extent));
            write_reg(CFG_V_SCALE, pick_scale(clamp_size(height_raw, MAX_HEIGHT), v_extent));
            write_reg(CFG_MAP_WIDTH, {23'($urandom), width_raw});
            write_reg(CFG_MAP_HEIGHT, {23'($urandom), height_raw});
            cfg_we <= 1'b0;

            // Phase 2 runs the sender flat out against a long receiver hold.
            quiet_phase = (phase == 2 || phase == 5);
            if (phase == 2)
                long_hold_cycles = LONG_HOLD;

            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 9) < 2)
                    offer_item(make_write(TADDR_W'($urandom), COLOR_W'($urandom)),
                               1'b0, 32'h0);
                else
                    offer_sample(pick_coord(u_origin_q, u_extent),
                                 pick_coord(v_origin_q, v_extent));
            end
        end

        quiesce();
        if (expected_colors.size() != 0)
        begin
            mismatch_count += expected_colors.size();
            $display("%0d expected results never arrived", expected_colors.size());
        end
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
